@@ hw/rtl/plir_pkg.sv @@
// ----------------------------------------------------------------------------
// plir_pkg
// Shared constants, command and status codes, and the per-cell control
// bundle of the positional list.
// ----------------------------------------------------------------------------
package plir_pkg;

	localparam int PLIR_CAPACITY    = 128;
	localparam int PLIR_HANDLE_BITS = 16;
	localparam int PLIR_GROUP       = 16;

	localparam int FUNC_W   = 3;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM_AT    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_READ      = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic ins;
		logic rem;
		logic tap;
	} plir_ctl_t;

endpackage

@@ hw/rtl/positional_list_insert_remove.sv @@
// An accepted item passes the valid_s1 stage and then the response register.
// Throughput: one item per cycle unless rsp_stall backs up; the cell row
// shifts on acceptance; the read tap goes through one registered OR stage.
// Reset: clears the entry count and the pipeline valids; the cell contents
// are not cleared and hold unknown values until written.
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Ordered handle list kept in a row of cells; insert and remove at front,
// back or any position, and read at a position, with status and count.
// ----------------------------------------------------------------------------
module positional_list_insert_remove #(
	parameter int CAPACITY    = plir_pkg::PLIR_CAPACITY,
	parameter int HANDLE_BITS = plir_pkg::PLIR_HANDLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [plir_pkg::FUNC_W-1:0]     func,
	input  logic [plir_pkg::POS_W-1:0]      position,
	input  logic [HANDLE_BITS-1:0]          handle_in,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [HANDLE_BITS-1:0]          handle_out,
	output logic [plir_pkg::STATUS_W-1:0]   status,
	output logic [plir_pkg::COUNT_W-1:0]    count_out
);
	import plir_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]    count_q;
	logic                valid_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [CNT_W-1:0]    cnt_s1;
	logic                rsp_valid_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    cnt_q;

	logic req_acc;
	logic rsp_adv;

	plir_ctl_t           dec_ctl;
	plir_ctl_t           ctl;
	logic [IDX_W-1:0]    at;
	logic [STATUS_W-1:0] st;
	logic [CNT_W-1:0]    cnt_next;
	logic [PW-1:0]       pos_w;
	logic [PW-1:0]       cnt_w;
	logic                full;
	logic                empty;

	logic [CAPACITY-1:0][HANDLE_BITS-1:0] cell_data;
	logic [CAPACITY-1:0][HANDLE_BITS-1:0] cell_tap;
	logic [HANDLE_BITS-1:0]               gathered;

	assign rsp_adv   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !rsp_adv;
	assign req_acc   = req_valid && !req_stall;

	assign full  = (count_q == CAP_CNT);
	assign empty = (count_q == '0);
	assign pos_w = PW'(position);
	assign cnt_w = PW'(count_q);

	always_comb begin
		dec_ctl = '0;
		at      = '0;
		st      = ST_OK;
		case (func)
			FN_INS_FRONT, FN_INS_AT, FN_INS_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else if (func == FN_INS_FRONT) begin
					dec_ctl.ins = 1'b1;
				end else if (func == FN_INS_BACK) begin
					dec_ctl.ins = 1'b1;
					at          = IDX_W'(count_q);
				end else if (pos_w > cnt_w) begin
					st = ST_RANGE;
				end else begin
					dec_ctl.ins = 1'b1;
					at          = IDX_W'(position);
				end
			end
			FN_REM_FRONT, FN_REM_AT, FN_REM_BACK, FN_READ: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (func == FN_REM_FRONT) begin
					dec_ctl.rem = 1'b1;
					dec_ctl.tap = 1'b1;
				end else if (func == FN_REM_BACK) begin
					dec_ctl.rem = 1'b1;
					dec_ctl.tap = 1'b1;
					at          = IDX_W'(count_q - CNT_W'(1));
				end else if (pos_w >= cnt_w) begin
					st = ST_RANGE;
				end else begin
					dec_ctl.rem = (func == FN_REM_AT);
					dec_ctl.tap = 1'b1;
					at          = IDX_W'(position);
				end
			end
			default: begin
				st = ST_RANGE;
			end
		endcase
	end

	assign ctl = req_acc ? dec_ctl : '0;

	always_comb begin
		cnt_next = count_q;
		if (dec_ctl.ins) begin
			cnt_next = count_q + CNT_W'(1);
		end else if (dec_ctl.rem) begin
			cnt_next = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [HANDLE_BITS-1:0] lower;
		logic [HANDLE_BITS-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = cell_data[i+1];
		end

		plir_cell #(
			.HANDLE_BITS (HANDLE_BITS),
			.IDX_W       (IDX_W),
			.INDEX       (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.at        (at),
			.handle_in (handle_in),
			.lower     (lower),
			.upper     (upper),
			.data      (cell_data[i]),
			.tap       (cell_tap[i])
		);
	end

	plir_gather #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_gather (
		.clk    (clk),
		.en     (req_acc),
		.taps   (cell_tap),
		.result (gathered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				count_q  <= cnt_next;
				valid_s1 <= 1'b1;
			end else if (rsp_adv) begin
				valid_s1 <= 1'b0;
			end
			if (rsp_adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			status_s1 <= st;
			cnt_s1    <= cnt_next;
		end
		if (rsp_adv && valid_s1) begin
			handle_q <= gathered;
			status_q <= status_s1;
			cnt_q    <= cnt_s1;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign handle_out = handle_q;
	assign status     = status_q;
	assign count_out  = COUNT_W'(cnt_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_ins_rem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.ins && ctl.rem))
		else $error("insert and remove in the same cycle");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != ST_OK) |-> handle_q == '0)
		else $error("flagged item returned a handle");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && st != ST_OK) |=> $stable(count_q))
		else $error("flagged item changed the count");

endmodule

@@ hw/rtl/plir_cell.sv @@
// ----------------------------------------------------------------------------
// plir_cell
// One list position: holds, loads, or takes the entry of its lower or upper
// neighbor under the broadcast command, and drives its entry on the read tap.
// ----------------------------------------------------------------------------
module plir_cell #(
	parameter int HANDLE_BITS = plir_pkg::PLIR_HANDLE_BITS,
	parameter int IDX_W       = 7,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  plir_pkg::plir_ctl_t    ctl,
	input  logic [IDX_W-1:0]       at,
	input  logic [HANDLE_BITS-1:0] handle_in,
	input  logic [HANDLE_BITS-1:0] lower,
	input  logic [HANDLE_BITS-1:0] upper,
	output logic [HANDLE_BITS-1:0] data,
	output logic [HANDLE_BITS-1:0] tap
);
	import plir_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [HANDLE_BITS-1:0] data_q;
	logic                   hit;
	logic                   above;

	assign hit   = (MY_IDX == at);
	assign above = (MY_IDX > at);

	always_ff @(posedge clk) begin
		if (ctl.ins && above) begin
			data_q <= lower;
		end else if (ctl.ins && hit) begin
			data_q <= handle_in;
		end else if (ctl.rem && (above || hit)) begin
			data_q <= upper;
		end
	end

	assign data = data_q;
	assign tap  = (ctl.tap && hit) ? data_q : '0;

endmodule

@@ hw/rtl/plir_gather.sv @@
// ----------------------------------------------------------------------------
// plir_gather
// Registered OR tree over the cell taps: groups are reduced and registered,
// then the group results are merged.
// ----------------------------------------------------------------------------
module plir_gather #(
	parameter int CAPACITY    = plir_pkg::PLIR_CAPACITY,
	parameter int HANDLE_BITS = plir_pkg::PLIR_HANDLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [CAPACITY-1:0][HANDLE_BITS-1:0] taps,
	output logic [HANDLE_BITS-1:0]               result
);
	import plir_pkg::*;

	localparam int NG = (CAPACITY + PLIR_GROUP - 1) / PLIR_GROUP;

	logic [NG*PLIR_GROUP-1:0][HANDLE_BITS-1:0] pad;
	logic [NG-1:0][HANDLE_BITS-1:0]            grp_s1;

	for (genvar i = 0; i < NG*PLIR_GROUP; i++) begin : g_pad
		if (i < CAPACITY) begin : g_real
			assign pad[i] = taps[i];
		end else begin : g_fill
			assign pad[i] = '0;
		end
	end

	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic [HANDLE_BITS-1:0] acc;

		always_comb begin
			acc = '0;
			for (int k = 0; k < PLIR_GROUP; k++) begin
				acc = acc | pad[g*PLIR_GROUP + k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				grp_s1[g] <= acc;
			end
		end
	end

	always_comb begin
		result = '0;
		for (int g = 0; g < NG; g++) begin
			result = result | grp_s1[g];
		end
	end

endmodule

@@ tb/positional_list_insert_remove_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove_tb
// Self-checking bench for the positional handle list. A short table of
// hand-picked commands runs first, then random commands that alternate
// between growing, mixed and draining stretches so that the list reaches
// both full and empty. Every accepted command is applied to a shadow list
// kept in a queue, and each response is compared in order against it.
// Both handshakes are throttled in phases, and the response side is held
// off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_tb;

	import plir_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 1227;
	localparam int DIRECTED_ROWS = 23;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP = 60;

	typedef struct packed {
		logic [PLIR_HANDLE_BITS-1:0] handle;
		logic [STATUS_W-1:0]         status;
		logic [COUNT_W-1:0]          count;
	} list_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0]           cmd;
		logic [POS_W-1:0]            pos;
		logic [PLIR_HANDLE_BITS-1:0] hnd;
		logic                        typed;
		list_result_t                want;
	} cmd_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        req_valid = 1'b0;
	logic                        req_stall;
	logic [FUNC_W-1:0]           func = '0;
	logic [POS_W-1:0]            position = '0;
	logic [PLIR_HANDLE_BITS-1:0] handle_in = '0;
	logic                        rsp_valid;
	logic                        rsp_stall = 1'b0;
	logic [PLIR_HANDLE_BITS-1:0] handle_out;
	logic [STATUS_W-1:0]         status;
	logic [COUNT_W-1:0]          count_out;

	logic [PLIR_HANDLE_BITS-1:0] shadow_list[$];
	list_result_t                pending_results[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_ask = 0;
	int hold_left = 0;
	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int peak_depth = 0;
	int cycle_count = 0;
	int status_tally[4] = '{0, 0, 0, 0};

	cmd_row_t directed_rows[DIRECTED_ROWS] = '{
		'{FN_REM_FRONT, 8'd0,   16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 8'd0}},
		'{FN_REM_AT,    8'd0,   16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 8'd0}},
		'{FN_REM_BACK,  8'd0,   16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 8'd0}},
		'{FN_READ,      8'd0,   16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 8'd0}},
		'{FN_INS_AT,    8'd1,   16'h1234, 1'b1, '{16'h0000, ST_RANGE, 8'd0}},
		'{FN_UNUSED,    8'd0,   16'hABCD, 1'b1, '{16'h0000, ST_RANGE, 8'd0}},
		'{FN_INS_FRONT, 8'd0,   16'hFFFF, 1'b1, '{16'h0000, ST_OK,    8'd1}},
		'{FN_INS_BACK,  8'd128, 16'h0000, 1'b1, '{16'h0000, ST_OK,    8'd2}},
		'{FN_INS_AT,    8'd2,   16'h8001, 1'b1, '{16'h0000, ST_OK,    8'd3}},
		'{FN_INS_AT,    8'd0,   16'h7FFE, 1'b1, '{16'h0000, ST_OK,    8'd4}},
		'{FN_INS_AT,    8'd5,   16'h0001, 1'b1, '{16'h0000, ST_RANGE, 8'd4}},
		'{FN_READ,      8'd3,   16'h0000, 1'b0, '{16'h0000, ST_OK,    8'd0}},
		'{FN_READ,      8'd4,   16'h0000, 1'b1, '{16'h0000, ST_RANGE, 8'd4}},
		'{FN_READ,      8'd128, 16'hFFFF, 1'b1, '{16'h0000, ST_RANGE, 8'd4}},
		'{FN_REM_AT,    8'd4,   16'h0000, 1'b1, '{16'h0000, ST_RANGE, 8'd4}},
		'{FN_REM_AT,    8'd1,   16'h0000, 1'b0, '{16'h0000, ST_OK,    8'd0}},
		'{FN_REM_BACK,  8'd0,   16'h0000, 1'b0, '{16'h0000, ST_OK,    8'd0}},
		'{FN_REM_FRONT, 8'd0,   16'h0000, 1'b0, '{16'h0000, ST_OK,    8'd0}},
		'{FN_READ,      8'd0,   16'h0000, 1'b0, '{16'h0000, ST_OK,    8'd0}},
		'{FN_UNUSED,    8'd128, 16'hFFFF, 1'b1, '{16'h0000, ST_RANGE, 8'd1}},
		'{FN_REM_AT,    8'd0,   16'h0000, 1'b0, '{16'h0000, ST_OK,    8'd0}},
		'{FN_INS_AT,    8'd0,   16'h5555, 1'b1, '{16'h0000, ST_OK,    8'd1}},
		'{FN_INS_AT,    8'd128, 16'hAAAA, 1'b1, '{16'h0000, ST_RANGE, 8'd1}}
	};

	positional_list_insert_remove uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.position   (position),
		.handle_in  (handle_in),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.handle_out (handle_out),
		.status     (status),
		.count_out  (count_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic list_result_t apply_list_cmd(input logic [FUNC_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic [PLIR_HANDLE_BITS-1:0] hnd);
		list_result_t res;
		int depth;
		depth = shadow_list.size();
		res = '0;
		res.status = ST_OK;
		case (cmd)
			FN_INS_FRONT, FN_INS_AT, FN_INS_BACK: begin
				if (depth >= PLIR_CAPACITY)
					res.status = ST_FULL;
				else if (cmd == FN_INS_FRONT)
					shadow_list.push_front(hnd);
				else if (cmd == FN_INS_BACK)
					shadow_list.push_back(hnd);
				else if (pos > depth)
					res.status = ST_RANGE;
				else
					shadow_list.insert(pos, hnd);
			end
			FN_REM_FRONT, FN_REM_AT, FN_REM_BACK, FN_READ: begin
				if (depth == 0)
					res.status = ST_EMPTY;
				else if (cmd == FN_REM_FRONT)
					res.handle = shadow_list.pop_front();
				else if (cmd == FN_REM_BACK)
					res.handle = shadow_list.pop_back();
				else if (pos >= depth)
					res.status = ST_RANGE;
				else if (cmd == FN_REM_AT) begin
					res.handle = shadow_list[pos];
					shadow_list.delete(pos);
				end else
					res.handle = shadow_list[pos];
			end
			default: res.status = ST_RANGE;
		endcase
		res.count = COUNT_W'(shadow_list.size());
		if (shadow_list.size() > peak_depth)
			peak_depth = shadow_list.size();
		return res;
	endfunction

	// hold valid through any stall; record the expected response on acceptance
	task automatic offer_item(input logic [FUNC_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [PLIR_HANDLE_BITS-1:0] hnd, input logic typed,
			input list_result_t want);
		list_result_t res;
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func <= cmd;
		position <= pos;
		handle_in <= hnd;
		do @(posedge clk); while (req_stall);
		res = apply_list_cmd(cmd, pos, hnd);
		if (typed)
			res = want;
		pending_results.push_back(res);
		items_sent++;
	endtask

	task automatic check_field(input string label, input logic [PLIR_HANDLE_BITS-1:0] want,
			input logic [PLIR_HANDLE_BITS-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (hold_ask != 0) begin
			hold_left = 300;
			hold_ask = 0;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else
			rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		list_result_t want;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			results_seen++;
			status_tally[status]++;
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected item, handle %0h status %0d count %0d",
					$time, handle_out, status, count_out);
			end else begin
				want = pending_results.pop_front();
				check_field("handle_out", want.handle, handle_out);
				check_field("status", 16'(want.status), 16'(status));
				check_field("count_out", 16'(want.count), 16'(count_out));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items outstanding", $time, pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int i;
		int depth;
		int seg;
		int ins_pct;
		int pick;
		logic [FUNC_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [PLIR_HANDLE_BITS-1:0] hnd;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++)
			offer_item(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].hnd,
				directed_rows[i].typed, directed_rows[i].want);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 307 == 0) begin
				case (i / 307)
					0: begin send_idle_pct = 0; stall_pct = 0; end
					1: begin send_idle_pct = 85; stall_pct = 0; end
					2: begin send_idle_pct = 0; stall_pct = 85; end
					default: begin send_idle_pct = 23; stall_pct = 23; end
				endcase
			end
			// back up the block while the sender keeps offering
			if (i == 120)
				hold_ask = 1;

			depth = shadow_list.size();
			seg = i % 450;
			ins_pct = (seg < 220) ? 85 : (seg < 260) ? 50 : 15;
			if ($urandom_range(99) < ins_pct)
				cmd = FUNC_W'($urandom_range(FN_INS_BACK));
			else
				cmd = FUNC_W'(FN_REM_FRONT + $urandom_range(3));
			if ($urandom_range(199) == 0)
				cmd = FN_UNUSED;

			pick = $urandom_range(9);
			if (pick < 7) begin
				if (cmd <= FN_INS_BACK)
					pos = POS_W'($urandom_range(depth));
				else
					pos = (depth == 0) ? '0 : POS_W'($urandom_range(depth - 1));
			end else if (pick < 9)
				pos = (depth + 2 > PLIR_CAPACITY) ? POS_W'(PLIR_CAPACITY - $urandom_range(1))
					: POS_W'(depth + $urandom_range(2));
			else
				pos = POS_W'($urandom_range(PLIR_CAPACITY));

			pick = $urandom_range(15);
			if (pick == 0)
				hnd = '0;
			else if (pick == 1)
				hnd = '1;
			else
				hnd = PLIR_HANDLE_BITS'($urandom_range(65535));

			offer_item(cmd, pos, hnd, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d commands, checked %0d responses, deepest list %0d entries.",
			items_sent, results_seen, peak_depth);
		$display("Responses by status: ok %0d, full %0d, empty %0d, out of range %0d.",
			status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
			status_tally[ST_RANGE]);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/plir_pkg.sv
hw/rtl/plir_cell.sv
hw/rtl/plir_gather.sv
hw/rtl/positional_list_insert_remove.sv
tb/positional_list_insert_remove_tb.sv
